>>> src/ladder_keypad_debounce_repeat_defines.svh
// Assertion macros for the ladder keypad debounce and auto-repeat block
`ifndef LADDER_KEYPAD_DEBOUNCE_REPEAT_DEFINES_SVH
`define LADDER_KEYPAD_DEBOUNCE_REPEAT_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define LKDR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define LKDR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/lkdr_pkg.sv
// Types and constants for the ladder keypad debounce and auto-repeat block
package lkdr_pkg;

  typedef enum logic [1:0] {
    OP_POLL     = 2'd0,
    OP_MS_TICK  = 2'd1,
    OP_SEC_TICK = 2'd2
  } op_e;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_INITIAL_REPEAT = 2'd0;
  localparam logic [1:0] REG_MIN_REPEAT     = 2'd1;
  localparam logic [1:0] REG_HOLD_SECONDS   = 2'd2;

  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned MS_W       = 11;
  localparam int unsigned SEC_W      = 4;
  localparam int unsigned HIST_W     = 16;
  localparam int unsigned NUM_LEVELS = 16;

  localparam logic [MS_W-1:0]  INITIAL_REPEAT_RST = 11'd1000;
  localparam logic [MS_W-1:0]  MIN_REPEAT_RST     = 11'd125;
  localparam logic [SEC_W-1:0] HOLD_SECONDS_RST   = 4'd3;

  // Ladder thresholds at 10-bit scale, highest voltage first
  localparam logic [9:0] KEY_LIMIT [NUM_LEVELS] = '{
    10'd967, 10'd864, 10'd782, 10'd714, 10'd657, 10'd608, 10'd566, 10'd529,
    10'd497, 10'd469, 10'd443, 10'd420, 10'd400, 10'd381, 10'd364, 10'd0
  };

  // Four equal samples of one key
  localparam logic [HIST_W-1:0] STEADY_DOWN  = 16'h1111;
  localparam logic [HIST_W-1:0] STEADY_UP    = 16'h2222;
  localparam logic [HIST_W-1:0] STEADY_ENTER = 16'h4444;
  localparam logic [HIST_W-1:0] STEADY_MODE  = 16'h8888;

  localparam logic [4:0] KEY_HOLD_TIMEOUT = 5'h10;

  typedef struct packed {
    logic [4:0] key_code;
    logic       power_off;
  } rsp_t;

endpackage

>>> src/lkdr_if.sv
// Request and response channel interfaces
interface lkdr_req_if #(
  parameter int unsigned ADC_BITS = 10
);
  logic                valid;
  logic                ready;
  logic [1:0]          opcode;
  logic [ADC_BITS-1:0] adc_value;

  modport source (output valid, output opcode, output adc_value, input ready);
  modport sink   (input valid, input opcode, input adc_value, output ready);
endinterface

interface lkdr_rsp_if;
  logic       valid;
  logic       ready;
  logic [4:0] key_code;
  logic       power_off;

  modport source (output valid, output key_code, output power_off, input ready);
  modport sink   (input valid, input key_code, input power_off, output ready);
endinterface

>>> src/ladder_keypad_debounce_repeat.sv
// Ladder keypad decoder with four-sample debounce, auto-repeat and hold timer
//
//  channel  | dir | payload                      | notes
//  ---------+-----+------------------------------+---------------------------------
//  req_i    | in  | opcode, adc_value[ADC_BITS]  | poll gives one response, ticks none
//  rsp_o    | out | key_code[5], power_off       | output register plus skid entry
//  APB      | in  | initial/min repeat, hold sec | regs at 0x0, 0x4, 0x8
//
// One request per cycle while req_i.ready is high: decode compares, history update
// and timers go straight from the accepted request into the state and response registers.
// A poll's response is registered in rsp_o the cycle after, unless it must wait in the skid entry.
// req_i.ready drops only while both the output register and the skid entry hold.
// rst_ni clears history, timers and response valids and loads register defaults.
`include "ladder_keypad_debounce_repeat_defines.svh"

module ladder_keypad_debounce_repeat #(
  parameter int unsigned ADC_BITS = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  lkdr_req_if.sink                            req_i,
  lkdr_rsp_if.source                          rsp_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lkdr_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [lkdr_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [lkdr_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  // Configuration
  logic [lkdr_pkg::MS_W-1:0]  init_rep_q, min_rep_q;
  logic [lkdr_pkg::SEC_W-1:0] hold_sec_q;
  logic                       cfg_wr;

  // Key state
  logic [lkdr_pkg::HIST_W-1:0] hist_q, hist_d, hist_new;
  logic [lkdr_pkg::MS_W-1:0]   period_q, period_d, period_half;
  logic [lkdr_pkg::MS_W-1:0]   rtimer_q, rtimer_d;
  logic [lkdr_pkg::SEC_W-1:0]  armed_q, armed_d;
  logic [lkdr_pkg::SEC_W-1:0]  htimer_q, htimer_d;

  // Decode
  logic [lkdr_pkg::NUM_LEVELS-1:0] hit;
  logic [3:0]                      key_idx;

  // Response path
  logic             req_acc, push, pop;
  lkdr_pkg::rsp_t   res, out_q, out_d, skid_q, skid_d;
  logic             out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;

  // ---------------------------------------------------------------- APB
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    case (paddr[3:2])
      lkdr_pkg::REG_INITIAL_REPEAT: prdata[lkdr_pkg::MS_W-1:0]  = init_rep_q;
      lkdr_pkg::REG_MIN_REPEAT:     prdata[lkdr_pkg::MS_W-1:0]  = min_rep_q;
      lkdr_pkg::REG_HOLD_SECONDS:   prdata[lkdr_pkg::SEC_W-1:0] = hold_sec_q;
      default:                      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_rep_q <= lkdr_pkg::INITIAL_REPEAT_RST;
      min_rep_q  <= lkdr_pkg::MIN_REPEAT_RST;
      hold_sec_q <= lkdr_pkg::HOLD_SECONDS_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        lkdr_pkg::REG_INITIAL_REPEAT: init_rep_q <= pwdata[lkdr_pkg::MS_W-1:0];
        lkdr_pkg::REG_MIN_REPEAT:     min_rep_q  <= pwdata[lkdr_pkg::MS_W-1:0];
        lkdr_pkg::REG_HOLD_SECONDS:   hold_sec_q <= pwdata[lkdr_pkg::SEC_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- decode
  // Thresholds rescaled from 10 bits to ADC_BITS at elaboration
  for (genvar k = 0; k < lkdr_pkg::NUM_LEVELS; k++) begin : g_thr
    localparam logic [ADC_BITS+9:0] WIDE = {lkdr_pkg::KEY_LIMIT[k], {ADC_BITS{1'b0}}};
    assign hit[k] = (req_i.adc_value >= WIDE[ADC_BITS+9:10]);
  end

  // First threshold met wins; the last one is zero so something always hits
  always_comb begin
    key_idx = '0;
    for (int k = lkdr_pkg::NUM_LEVELS - 1; k >= 0; k--) begin
      if (hit[k]) key_idx = 4'(k);
    end
  end

  // ---------------------------------------------------------------- key state
  assign req_acc     = req_i.valid && req_i.ready;
  assign hist_new    = {hist_q[lkdr_pkg::HIST_W-5:0], key_idx};
  assign period_half = (period_q > min_rep_q) ? (period_q >> 1) : period_q;

  always_comb begin
    hist_d   = hist_q;
    period_d = period_q;
    rtimer_d = rtimer_q;
    armed_d  = armed_q;
    htimer_d = htimer_q;
    push     = 1'b0;
    res      = '0;
    if (req_acc) begin
      case (lkdr_pkg::op_e'(req_i.opcode))
        lkdr_pkg::OP_POLL: begin
          push = 1'b1;
          if (hist_new != hist_q) begin
            hist_d = hist_new;
            if (hist_new == lkdr_pkg::STEADY_UP || hist_new == lkdr_pkg::STEADY_DOWN) begin
              period_d     = init_rep_q;
              rtimer_d     = init_rep_q;
              res.key_code = {1'b0, hist_new[3:0]};
            end else if (hist_new == lkdr_pkg::STEADY_ENTER ||
                         hist_new == lkdr_pkg::STEADY_MODE) begin
              period_d     = '0;
              armed_d      = hold_sec_q;
              htimer_d     = hold_sec_q;
              res.key_code = {1'b0, hist_new[3:0]};
            end else if (hist_new == '0) begin
              period_d = '0;
              armed_d  = '0;
            end
          end else if (period_q != '0 && rtimer_q == '0) begin
            // repeat due: halve the period while it is above the minimum
            period_d     = period_half;
            rtimer_d     = period_half;
            res.key_code = {1'b0, hist_new[3:0]};
          end else if (armed_q != '0 && htimer_q == '0) begin
            if (hist_new == lkdr_pkg::STEADY_MODE) res.power_off = 1'b1;
            else                                    res.key_code  = lkdr_pkg::KEY_HOLD_TIMEOUT;
          end
        end
        lkdr_pkg::OP_MS_TICK: begin
          if (rtimer_q != '0) rtimer_d = rtimer_q - 11'd1;
        end
        lkdr_pkg::OP_SEC_TICK: begin
          if (htimer_q != '0) htimer_d = htimer_q - 4'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q   <= '0;
      period_q <= '0;
      rtimer_q <= '0;
      armed_q  <= '0;
      htimer_q <= '0;
    end else begin
      hist_q   <= hist_d;
      period_q <= period_d;
      rtimer_q <= rtimer_d;
      armed_q  <= armed_d;
      htimer_q <= htimer_d;
    end
  end

  // ---------------------------------------------------------------- response
  assign req_i.ready = !skid_valid_q;
  assign pop         = out_valid_q && rsp_o.ready;

  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_d       = res;
        skid_valid_d = push;
      end else begin
        out_d       = res;
        out_valid_d = push;
      end
    end else if (push) begin
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.key_code  = out_q.key_code;
  assign rsp_o.power_off = out_q.power_off;

  // ---------------------------------------------------------------- checks
  `LKDR_ASSERT_NOW(a_skid_behind_out, clk_i, rst_ni, skid_valid_q, out_valid_q, "skid entry held with empty output register")
  `LKDR_ASSERT_NOW(a_poff_no_code, clk_i, rst_ni, out_valid_q && out_q.power_off, out_q.key_code == '0, "power off reported with a key code")
  `LKDR_ASSERT_NEXT(a_tick_no_rsp, clk_i, rst_ni, req_acc && req_i.opcode != lkdr_pkg::OP_POLL && !out_valid_q, !out_valid_q, "tick produced a response")
  `LKDR_ASSERT_NEXT(a_skid_drains, clk_i, rst_ni, pop && skid_valid_q, out_valid_q, "skid entry lost on output pop")

endmodule
